[rtl/gccsb_pkg.sv]
// shared constants, codes and controller/datapath interface types for the grid binner
`default_nettype none

package gccsb_pkg;

   // default values of the top-level parameters
   localparam int GRID_SIDE_DEF     = 64;
   localparam int MAX_PARTICLES_DEF = 1024;
   localparam int COORD_BITS_DEF    = 16;

   // fixed field widths
   localparam int MODE_W   = 2;
   localparam int CNT_W    = 11;
   localparam int CIDX_W   = 12;
   localparam int SLOT_W   = 11;
   localparam int PID_W    = 10;
   localparam int CSIZE_W  = 12;
   localparam int REM_W    = CSIZE_W + 1;

   // configuration port
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_IDX_W  = CSR_ADDR_W - 2;
   localparam logic [CSR_IDX_W-1:0] REG_CELL_SIZE = 1'b0;
   localparam logic [CSIZE_W-1:0]   CELL_SIZE_RST = 12'd16;

   // saturation limit of every count, start and slot
   localparam logic [CNT_W-1:0] CNT_MAX = '1;

   // operation codes
   localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd0;
   localparam logic [MODE_W-1:0] MODE_COUNT = 2'd1;
   localparam logic [MODE_W-1:0] MODE_BUILD = 2'd2;
   localparam logic [MODE_W-1:0] MODE_PLACE = 2'd3;

   // controller to datapath commands
   typedef struct packed {
      logic capture;
      logic div_step;
      logic mul_step;
      logic lin_step;
      logic mem_rd;
      logic update;
      logic sweep_en;
      logic clr_cnt;
      logic clr_plc;
      logic build_rd;
      logic emit;
   } ctrl_cmd_type;

   // datapath to controller status
   typedef struct packed {
      logic div_last;
      logic sweep_last;
   } dp_status_type;

endpackage

`default_nettype wire

[rtl/grid_cell_counting_sort_binner_core.sv]
// top level of the grid binner: configuration register, controller and datapath
`default_nettype none

// Counting-sort binner for a GRID_SIDE x GRID_SIDE grid. A transaction is taken when
// start is high and busy is low; each transaction gives one result, shown on the rsp_
// ports for one cycle with rsp_valid, which the receiver cannot hold off. Count and place
// transactions (modes 1 and 3) keep busy high while the divider resolves one quotient bit
// of both coordinates per cycle, followed by the row multiply, the range check, the memory
// read and the update. Clear and build transactions (modes 0 and 2) walk every cell
// through one memory port a cycle and keep busy high for the walk and the closing state;
// a build also passes the drain state before it. The result strobe comes in the cycle
// after the last busy cycle. After reset the block runs a clearing pass over the count
// and placement memories with busy high; configuration writes are taken throughout.
// Placing a particle before any build transaction gives an undefined slot.

module grid_cell_counting_sort_binner_core #(
   parameter int GRID_SIDE     = gccsb_pkg::GRID_SIDE_DEF,
   parameter int MAX_PARTICLES = gccsb_pkg::MAX_PARTICLES_DEF,
   parameter int COORD_BITS    = gccsb_pkg::COORD_BITS_DEF
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   // input channel
   input  wire logic                             start,
   output logic                                  busy,
   input  wire logic [gccsb_pkg::MODE_W-1:0]     req_mode,
   input  wire logic [COORD_BITS-1:0]            req_pos_x,
   input  wire logic [COORD_BITS-1:0]            req_pos_y,
   input  wire logic [gccsb_pkg::PID_W-1:0]      req_particle_id,
   // result channel
   output logic                                  rsp_valid,
   output logic                                  rsp_in_range,
   output logic [gccsb_pkg::CIDX_W-1:0]          rsp_cell_index,
   output logic [gccsb_pkg::SLOT_W-1:0]          rsp_slot,
   output logic [gccsb_pkg::PID_W-1:0]           rsp_particle_id_out,
   output logic                                  rsp_overflow,
   // configuration port
   input  wire logic                             psel,
   input  wire logic                             penable,
   input  wire logic                             pwrite,
   input  wire logic [gccsb_pkg::CSR_ADDR_W-1:0] paddr,
   input  wire logic [gccsb_pkg::CSR_DATA_W-1:0] pwdata,
   output logic [gccsb_pkg::CSR_DATA_W-1:0]      prdata,
   output logic                                  pready
);
   import gccsb_pkg::*;

   logic [CSIZE_W-1:0]   csr_cell_size_ff;
   logic [CSR_IDX_W-1:0] csr_index;
   logic                 csr_write;
   ctrl_cmd_type         cmd;
   dp_status_type        status;

   // register decode; byte offset within the word is ignored
   assign csr_index = paddr[CSR_ADDR_W-1:2];
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_cell_size_ff <= CELL_SIZE_RST;
      end else if (csr_write && csr_index == REG_CELL_SIZE) begin
         csr_cell_size_ff <= pwdata[CSIZE_W-1:0];
      end
   end

   // read back
   always_comb begin
      prdata = '0;
      if (csr_index == REG_CELL_SIZE) prdata = CSR_DATA_W'(csr_cell_size_ff);
   end

   gccsb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .req_mode  (req_mode),
      .status    (status),
      .cmd       (cmd),
      .busy      (busy),
      .rsp_valid (rsp_valid)
   );

   gccsb_dp #(
      .GRID_SIDE     (GRID_SIDE),
      .MAX_PARTICLES (MAX_PARTICLES),
      .COORD_BITS    (COORD_BITS)
   ) u_dp (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .status              (status),
      .req_mode            (req_mode),
      .req_pos_x           (req_pos_x),
      .req_pos_y           (req_pos_y),
      .req_particle_id     (req_particle_id),
      .cell_size           (csr_cell_size_ff),
      .rsp_in_range        (rsp_in_range),
      .rsp_cell_index      (rsp_cell_index),
      .rsp_slot            (rsp_slot),
      .rsp_particle_id_out (rsp_particle_id_out),
      .rsp_overflow        (rsp_overflow)
   );

endmodule

`default_nettype wire

[rtl/gccsb_ctrl.sv]
// sequencing state machine of the grid binner
`default_nettype none

module gccsb_ctrl (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     start,
   input  wire logic [gccsb_pkg::MODE_W-1:0] req_mode,
   input  wire gccsb_pkg::dp_status_type status,
   output gccsb_pkg::ctrl_cmd_type       cmd,
   output logic                          busy,
   output logic                          rsp_valid
);
   import gccsb_pkg::*;

   localparam int ST_W = 4;
   localparam logic [ST_W-1:0] S_INIT    = 4'd0;
   localparam logic [ST_W-1:0] S_IDLE    = 4'd1;
   localparam logic [ST_W-1:0] S_CLR     = 4'd2;
   localparam logic [ST_W-1:0] S_BUILD   = 4'd3;
   localparam logic [ST_W-1:0] S_BLD_END = 4'd4;
   localparam logic [ST_W-1:0] S_DONE    = 4'd5;
   localparam logic [ST_W-1:0] S_DIV     = 4'd6;
   localparam logic [ST_W-1:0] S_MUL     = 4'd7;
   localparam logic [ST_W-1:0] S_LIN     = 4'd8;
   localparam logic [ST_W-1:0] S_READ    = 4'd9;
   localparam logic [ST_W-1:0] S_UPD     = 4'd10;

   logic [ST_W-1:0] state_ff;
   logic [ST_W-1:0] state_in;
   logic            rsp_valid_ff;

   // next state and commands
   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      case (state_ff)
         S_INIT: begin
            cmd.sweep_en = 1'b1;
            cmd.clr_cnt  = 1'b1;
            cmd.clr_plc  = 1'b1;
            if (status.sweep_last) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (start) begin
               cmd.capture = 1'b1;
               case (req_mode)
                  MODE_CLEAR: state_in = S_CLR;
                  MODE_BUILD: state_in = S_BUILD;
                  default:    state_in = S_DIV;
               endcase
            end
         end
         S_CLR: begin
            cmd.sweep_en = 1'b1;
            cmd.clr_cnt  = 1'b1;
            if (status.sweep_last) state_in = S_DONE;
         end
         S_BUILD: begin
            cmd.sweep_en = 1'b1;
            cmd.build_rd = 1'b1;
            if (status.sweep_last) state_in = S_BLD_END;
         end
         // last start write drains from the read pipeline
         S_BLD_END: state_in = S_DONE;
         S_DONE: begin
            cmd.emit = 1'b1;
            state_in = S_IDLE;
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            if (status.div_last) state_in = S_MUL;
         end
         S_MUL: begin
            cmd.mul_step = 1'b1;
            state_in     = S_LIN;
         end
         S_LIN: begin
            cmd.lin_step = 1'b1;
            state_in     = S_READ;
         end
         S_READ: begin
            cmd.mem_rd = 1'b1;
            state_in   = S_UPD;
         end
         S_UPD: begin
            cmd.update = 1'b1;
            cmd.emit   = 1'b1;
            state_in   = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   // state and result strobe
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_INIT;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= cmd.emit;
      end
   end

   assign busy      = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   // result strobe lasts a single cycle
   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe held longer than one cycle");

   // an accepted transaction makes the block busy
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted transaction did not raise busy");

   // a result only follows work in progress
   a_result_after_work: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy))
      else $error("result without a transaction in progress");

endmodule

`default_nettype wire

[rtl/gccsb_dp.sv]
// datapath of the grid binner: divider, cell mapping, cell memories and result registers
`default_nettype none

module gccsb_dp #(
   parameter int GRID_SIDE     = gccsb_pkg::GRID_SIDE_DEF,
   parameter int MAX_PARTICLES = gccsb_pkg::MAX_PARTICLES_DEF,
   parameter int COORD_BITS    = gccsb_pkg::COORD_BITS_DEF
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire gccsb_pkg::ctrl_cmd_type       cmd,
   output gccsb_pkg::dp_status_type           status,
   input  wire logic [gccsb_pkg::MODE_W-1:0]  req_mode,
   input  wire logic [COORD_BITS-1:0]         req_pos_x,
   input  wire logic [COORD_BITS-1:0]         req_pos_y,
   input  wire logic [gccsb_pkg::PID_W-1:0]   req_particle_id,
   input  wire logic [gccsb_pkg::CSIZE_W-1:0] cell_size,
   output logic                               rsp_in_range,
   output logic [gccsb_pkg::CIDX_W-1:0]       rsp_cell_index,
   output logic [gccsb_pkg::SLOT_W-1:0]       rsp_slot,
   output logic [gccsb_pkg::PID_W-1:0]        rsp_particle_id_out,
   output logic                               rsp_overflow
);
   import gccsb_pkg::*;

   localparam int NCELLS = GRID_SIDE * GRID_SIDE;
   localparam int IDX_W  = $clog2(NCELLS);
   localparam int LIN_W  = COORD_BITS + 10;
   localparam int DCNT_W = $clog2(COORD_BITS);
   localparam logic [IDX_W-1:0]        LAST_CELL = IDX_W'(NCELLS - 1);
   localparam logic [DCNT_W-1:0]       LAST_STEP = DCNT_W'(COORD_BITS - 1);
   localparam logic signed [LIN_W-1:0] SIDE_S    = LIN_W'(GRID_SIDE);
   localparam logic signed [LIN_W-1:0] NCELLS_S  = LIN_W'(NCELLS);
   localparam logic [31:0]             MAXP      = 32'(MAX_PARTICLES);

   // cell memories
   logic [CNT_W-1:0] cnt_mem   [NCELLS];
   logic [CNT_W-1:0] start_mem [NCELLS];
   logic [CNT_W-1:0] plc_mem   [NCELLS];

   // captured transaction
   logic [MODE_W-1:0]  mode_ff;
   logic [PID_W-1:0]   pid_ff;
   logic [CSIZE_W-1:0] dvs_ff;
   logic               sx_ff, sy_ff;

   // divider lanes
   logic [COORD_BITS-1:0] dvx_ff, dvy_ff, dvx_in, dvy_in;
   logic [REM_W-1:0]      rmx_ff, rmy_ff, rmx_in, rmy_in;
   logic [REM_W-1:0]      rmx_sh, rmy_sh;
   logic [DCNT_W-1:0]     dcnt_ff;

   // mapping
   logic signed [LIN_W-1:0] gx, gy, gym;
   logic signed [LIN_W-1:0] gx_ff, gym_ff, lin;
   logic [IDX_W-1:0]        idx_ff;
   logic                    rng_ff;

   // sweep and offset build
   logic [IDX_W-1:0] sweep_ff;
   logic             bld_vld_ff;
   logic [IDX_W-1:0] bld_addr_ff;
   logic [CNT_W-1:0] sum_ff;
   logic             bld_ovf_ff;
   logic [CNT_W:0]   sum_wide;

   // memory read data
   logic [CNT_W-1:0] cnt_rd_ff, start_rd_ff, plc_rd_ff;

   // update decisions
   logic             cnt_full, plc_full;
   logic [CNT_W:0]   slot_wide;
   logic             slot_ovf;
   logic [CNT_W-1:0] slot_sat;

   // memory write ports
   logic             cnt_we, plc_we;
   logic [IDX_W-1:0] cnt_wa, plc_wa, cnt_ra;
   logic [CNT_W-1:0] cnt_wd, plc_wd;

   // divider step: shift in the next dividend bit, subtract when it fits
   always_comb begin
      rmx_sh = {rmx_ff[REM_W-2:0], dvx_ff[COORD_BITS-1]};
      rmy_sh = {rmy_ff[REM_W-2:0], dvy_ff[COORD_BITS-1]};
      rmx_in = rmx_sh;
      rmy_in = rmy_sh;
      dvx_in = {dvx_ff[COORD_BITS-2:0], 1'b0};
      dvy_in = {dvy_ff[COORD_BITS-2:0], 1'b0};
      if (rmx_sh >= {1'b0, dvs_ff}) begin
         rmx_in    = rmx_sh - {1'b0, dvs_ff};
         dvx_in[0] = 1'b1;
      end
      if (rmy_sh >= {1'b0, dvs_ff}) begin
         rmy_in    = rmy_sh - {1'b0, dvs_ff};
         dvy_in[0] = 1'b1;
      end
   end

   // capture and division
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         mode_ff <= req_mode;
         pid_ff  <= req_particle_id;
         dvs_ff  <= (cell_size == '0) ? CSIZE_W'(1) : cell_size;
         sx_ff   <= req_pos_x[COORD_BITS-1];
         sy_ff   <= req_pos_y[COORD_BITS-1];
         dvx_ff  <= req_pos_x[COORD_BITS-1] ? (~req_pos_x + 1'b1) : req_pos_x;
         dvy_ff  <= req_pos_y[COORD_BITS-1] ? (~req_pos_y + 1'b1) : req_pos_y;
         rmx_ff  <= '0;
         rmy_ff  <= '0;
      end else if (cmd.div_step) begin
         dvx_ff <= dvx_in;
         dvy_ff <= dvy_in;
         rmx_ff <= rmx_in;
         rmy_ff <= rmy_in;
      end
   end

   // signed quotients, then row offset through a constant multiply
   always_comb begin
      gx  = sx_ff ? -$signed(LIN_W'(dvx_ff)) : $signed(LIN_W'(dvx_ff));
      gy  = sy_ff ? -$signed(LIN_W'(dvy_ff)) : $signed(LIN_W'(dvy_ff));
      gym = LIN_W'(gy * SIDE_S);
      lin = gx_ff + gym_ff;
   end

   always_ff @(posedge clock) begin
      if (cmd.mul_step) begin
         gx_ff  <= gx;
         gym_ff <= gym;
      end
      if (cmd.lin_step) begin
         rng_ff <= !lin[LIN_W-1] && (lin < NCELLS_S);
         idx_ff <= lin[IDX_W-1:0];
      end
   end

   // step and sweep counters
   always_ff @(posedge clock) begin
      if (reset) begin
         dcnt_ff    <= '0;
         sweep_ff   <= '0;
         bld_vld_ff <= 1'b0;
      end else begin
         if (cmd.capture) dcnt_ff <= '0;
         else if (cmd.div_step) dcnt_ff <= dcnt_ff + 1'b1;
         if (cmd.sweep_en) sweep_ff <= (sweep_ff == LAST_CELL) ? '0 : sweep_ff + 1'b1;
         bld_vld_ff <= cmd.build_rd;
      end
   end

   assign status.div_last   = (dcnt_ff == LAST_STEP);
   assign status.sweep_last = (sweep_ff == LAST_CELL);

   // running exclusive prefix sum with saturation
   assign sum_wide = {1'b0, sum_ff} + {1'b0, cnt_rd_ff};

   always_ff @(posedge clock) begin
      bld_addr_ff <= sweep_ff;
      if (cmd.capture) begin
         sum_ff     <= '0;
         bld_ovf_ff <= 1'b0;
      end else if (bld_vld_ff) begin
         if (sum_wide > {1'b0, CNT_MAX}) begin
            sum_ff     <= CNT_MAX;
            bld_ovf_ff <= 1'b1;
         end else begin
            sum_ff <= sum_wide[CNT_W-1:0];
         end
      end
   end

   // count and place decisions
   always_comb begin
      cnt_full  = (cnt_rd_ff == CNT_MAX);
      plc_full  = (plc_rd_ff == CNT_MAX);
      slot_wide = {1'b0, start_rd_ff} + {1'b0, plc_rd_ff};
      slot_ovf  = (32'(slot_wide) >= MAXP) || (slot_wide > {1'b0, CNT_MAX});
      slot_sat  = (slot_wide > {1'b0, CNT_MAX}) ? CNT_MAX : slot_wide[CNT_W-1:0];
   end

   // write port selection
   always_comb begin
      cnt_ra = cmd.build_rd ? sweep_ff : idx_ff;
      cnt_we = 1'b0;
      cnt_wa = idx_ff;
      cnt_wd = cnt_rd_ff + 1'b1;
      if (cmd.clr_cnt) begin
         cnt_we = 1'b1;
         cnt_wa = sweep_ff;
         cnt_wd = '0;
      end else if (cmd.update && rng_ff && mode_ff == MODE_COUNT && !cnt_full) begin
         cnt_we = 1'b1;
      end

      plc_we = 1'b0;
      plc_wa = idx_ff;
      plc_wd = plc_rd_ff + 1'b1;
      if (cmd.clr_plc) begin
         plc_we = 1'b1;
         plc_wa = sweep_ff;
         plc_wd = '0;
      end else if (bld_vld_ff) begin
         plc_we = 1'b1;
         plc_wa = bld_addr_ff;
         plc_wd = '0;
      end else if (cmd.update && rng_ff && mode_ff == MODE_PLACE && !plc_full) begin
         plc_we = 1'b1;
      end
   end

   // count memory
   always_ff @(posedge clock) begin
      if (cnt_we) cnt_mem[cnt_wa] <= cnt_wd;
      if (cmd.build_rd || cmd.mem_rd) cnt_rd_ff <= cnt_mem[cnt_ra];
   end

   // start memory
   always_ff @(posedge clock) begin
      if (bld_vld_ff) start_mem[bld_addr_ff] <= sum_ff;
      if (cmd.mem_rd) start_rd_ff <= start_mem[idx_ff];
   end

   // placement counter memory
   always_ff @(posedge clock) begin
      if (plc_we) plc_mem[plc_wa] <= plc_wd;
      if (cmd.mem_rd) plc_rd_ff <= plc_mem[idx_ff];
   end

   // result registers
   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_in_range        <= 1'b0;
         rsp_cell_index      <= '0;
         rsp_slot            <= '0;
         rsp_particle_id_out <= '0;
         rsp_overflow        <= 1'b0;
         case (mode_ff)
            MODE_CLEAR: begin
            end
            MODE_BUILD: begin
               rsp_slot     <= sum_ff;
               rsp_overflow <= bld_ovf_ff;
            end
            MODE_COUNT: begin
               rsp_particle_id_out <= pid_ff;
               rsp_in_range        <= rng_ff;
               rsp_cell_index      <= rng_ff ? CIDX_W'(idx_ff) : '0;
               rsp_overflow        <= rng_ff && cnt_full;
            end
            default: begin
               rsp_particle_id_out <= pid_ff;
               rsp_in_range        <= rng_ff;
               rsp_cell_index      <= rng_ff ? CIDX_W'(idx_ff) : '0;
               rsp_slot            <= rng_ff ? slot_sat : '0;
               rsp_overflow        <= rng_ff && slot_ovf;
            end
         endcase
      end
   end

endmodule

`default_nettype wire
